// ===== hdl/mpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Monochrome pixel converter package
// Shared types, mode codes and constants for the luminance datapath.
// ----------------------------------------------------------------------------
package mpc_pkg;

    // Mode selector carried with each input word
    typedef enum logic [1:0] {
        FUNC_TEXEL    = 2'd0,
        FUNC_UNSIGNED = 2'd1,
        FUNC_SIGNED   = 2'd2,
        FUNC_RSVD     = 2'd3
    } t_func;

    // One input word as held in the input register
    typedef struct packed {
        t_func              func;
        logic [15:0]        texel;
        logic signed [15:0] chan_r;
        logic signed [15:0] chan_g;
        logic signed [15:0] chan_b;
    } t_item;

    // One result word as held in the result register
    typedef struct packed {
        logic [15:0]        texel_out;
        logic signed [15:0] gray;
    } t_result;

    // Luminance weights, sum width covers 16-bit signed channels times 256
    localparam int                 SumW    = 25;
    localparam logic signed [24:0] LUMA_KR = 25'sd77;
    localparam logic signed [24:0] LUMA_KG = 25'sd150;
    localparam logic signed [24:0] LUMA_KB = 25'sd29;

    // Clamp limits for the signed mode
    localparam logic signed [16:0] GRAY_MIN = -17'sd1024;
    localparam logic signed [16:0] GRAY_MAX = 17'sd1023;

    // Reciprocal of 17 for values up to 263: q = (t * 241) >> 12
    localparam logic [15:0] RECIP17 = 16'd241;
    localparam logic [8:0]  ROUND17 = 9'd8;

    // 5-bit to 8-bit expansion, floor(x * 255 / 31)
    localparam logic [7:0] EXPAND5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

endpackage
`default_nettype wire

// ===== hdl/mpc_convert.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Monochrome pixel converter datapath
// Channel selection, luminance sum, requantisation and clamping for one word.
// ----------------------------------------------------------------------------
module mpc_convert (
    input  wire logic            i_enable,
    input  wire mpc_pkg::t_item  i_item,
    output mpc_pkg::t_result     o_result
);

    logic                                 w_opaque;
    logic signed [15:0]                   w_lr;
    logic signed [15:0]                   w_lg;
    logic signed [15:0]                   w_lb;
    logic signed [mpc_pkg::SumW-1:0]      w_sum;
    logic [7:0]                           w_luma8;
    logic [12:0]                          w_y31;
    logic [13:0]                          w_div255;
    logic [4:0]                           w_v5;
    logic [8:0]                           w_t17;
    logic [15:0]                          w_div17;
    logic [3:0]                           w_v4;
    logic signed [16:0]                   w_lsh;
    logic signed [16:0]                   w_clamp;

    assign w_opaque = i_item.texel[15];

    // Pick the channels fed to the luminance sum
    always_comb begin
        case (i_item.func)
            mpc_pkg::FUNC_TEXEL: begin
                if (w_opaque) begin
                    w_lr = {8'd0, mpc_pkg::EXPAND5_LUT[i_item.texel[14:10]]};
                    w_lg = {8'd0, mpc_pkg::EXPAND5_LUT[i_item.texel[9:5]]};
                    w_lb = {8'd0, mpc_pkg::EXPAND5_LUT[i_item.texel[4:0]]};
                end else begin
                    w_lr = {8'd0, i_item.texel[11:8], i_item.texel[11:8]};
                    w_lg = {8'd0, i_item.texel[7:4], i_item.texel[7:4]};
                    w_lb = {8'd0, i_item.texel[3:0], i_item.texel[3:0]};
                end
            end
            mpc_pkg::FUNC_UNSIGNED: begin
                w_lr = {8'd0, i_item.chan_r[7:0]};
                w_lg = {8'd0, i_item.chan_g[7:0]};
                w_lb = {8'd0, i_item.chan_b[7:0]};
            end
            default: begin
                w_lr = i_item.chan_r;
                w_lg = i_item.chan_g;
                w_lb = i_item.chan_b;
            end
        endcase
    end

    // Weighted luminance sum
    assign w_sum = mpc_pkg::SumW'(w_lr) * mpc_pkg::LUMA_KR
                 + mpc_pkg::SumW'(w_lg) * mpc_pkg::LUMA_KG
                 + mpc_pkg::SumW'(w_lb) * mpc_pkg::LUMA_KB;

    assign w_luma8 = w_sum[15:8];

    // Opaque requantise: floor(l * 31 / 255) via the divide-by-255 identity
    assign w_y31    = {w_luma8, 5'd0} - {5'd0, w_luma8};
    assign w_div255 = 14'(w_y31) + 14'(w_y31[12:8]) + 14'd1;
    assign w_v5     = w_div255[12:8];

    // Translucent requantise: floor((l + 8) / 17) by reciprocal multiply
    assign w_t17   = {1'b0, w_luma8} + mpc_pkg::ROUND17;
    assign w_div17 = 16'(w_t17) * mpc_pkg::RECIP17;
    assign w_v4    = w_div17[15:12];

    // Floor shift and clamp for the signed mode
    assign w_lsh = w_sum[24:8];

    always_comb begin
        if (w_lsh < mpc_pkg::GRAY_MIN) begin
            w_clamp = mpc_pkg::GRAY_MIN;
        end else if (w_lsh > mpc_pkg::GRAY_MAX) begin
            w_clamp = mpc_pkg::GRAY_MAX;
        end else begin
            w_clamp = w_lsh;
        end
    end

    // Assemble the result word
    always_comb begin
        o_result.texel_out = 16'd0;
        o_result.gray      = 16'sd0;
        case (i_item.func)
            mpc_pkg::FUNC_TEXEL: begin
                if (!i_enable) begin
                    o_result.texel_out = i_item.texel;
                end else if (w_opaque) begin
                    o_result.texel_out = {1'b1, w_v5, w_v5, w_v5};
                end else begin
                    o_result.texel_out = {1'b0, i_item.texel[14:12], w_v4, w_v4, w_v4};
                end
            end
            mpc_pkg::FUNC_UNSIGNED: begin
                o_result.gray = i_enable ? $signed({8'd0, w_luma8}) : i_item.chan_r;
            end
            mpc_pkg::FUNC_SIGNED: begin
                o_result.gray = i_enable ? 16'(w_clamp) : i_item.chan_r;
            end
            default: begin
                o_result.texel_out = 16'd0;
                o_result.gray      = 16'sd0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/monochrome_pixel_converter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Monochrome pixel converter
// Grayscale conversion of RGB5A3 texels and of 8-bit or signed colours.
// ----------------------------------------------------------------------------
// Takes one word per cycle while o_in_stall is low and returns one result
// word per input word, in order. A word passes through an input register,
// the conversion logic and a result register, and its result is offered
// once it is in the result register; with no output stall the
// block sustains one word every cycle. The input stalls only when both
// registers are full and the output is stalled. The enable register resets
// to 1 and should be written only while the block is empty; writes are
// always taken at once.
module monochrome_pixel_converter_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic [15:0]        i_texel_in,
    input  wire logic signed [15:0] i_chan_r,
    input  wire logic signed [15:0] i_chan_g,
    input  wire logic signed [15:0] i_chan_b,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [15:0]             o_texel_out,
    output logic signed [15:0]      o_gray
);

    logic               r_enable;
    logic               r_s1_vld;
    logic               r_s2_vld;
    mpc_pkg::t_item     r_s1;
    mpc_pkg::t_result   r_s2;
    mpc_pkg::t_result   w_result;
    logic               w_s2_free;
    logic               w_s1_move;
    logic               w_s1_free;
    logic               w_in_acc;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_data;
        end
    end

    // Pipeline flow control
    assign w_s2_free  = !r_s2_vld || !i_out_stall;
    assign w_s1_move  = r_s1_vld && w_s2_free;
    assign w_s1_free  = !r_s1_vld || w_s2_free;
    assign o_in_stall = !w_s1_free;
    assign w_in_acc   = i_in_valid && w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1.func   <= mpc_pkg::t_func'(i_func);
            r_s1.texel  <= i_texel_in;
            r_s1.chan_r <= i_chan_r;
            r_s1.chan_g <= i_chan_g;
            r_s1.chan_b <= i_chan_b;
        end
    end

    mpc_convert u_convert (
        .i_enable (r_enable),
        .i_item   (r_s1),
        .o_result (w_result)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s2 <= w_result;
        end
    end

    assign o_out_valid = r_s2_vld;
    assign o_texel_out = r_s2.texel_out;
    assign o_gray      = r_s2.gray;

    // Input stalls only with both stages full and the output blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_s2_vld && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // A reserved mode word yields an all-zero result
    a_rsvd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && (r_s1.func == mpc_pkg::FUNC_RSVD))
        |=> (o_texel_out == 16'd0 && o_gray == 16'sd0))
        else $error("reserved mode produced a nonzero word");

    // Signed mode output stays within the clamp range
    a_signed_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_move && r_enable && (r_s1.func == mpc_pkg::FUNC_SIGNED))
        |=> (o_gray >= 16'shFC00 && o_gray <= 16'sd1023))
        else $error("signed gray outside clamp range");

    // A held result word does not change while stalled
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_s2)))
        else $error("stalled result word changed");

endmodule
`default_nettype wire
